// File: rtl/core/tpbe_pkg.sv
package tpbe_pkg;

	// sample counter width; holds silence runs and segment lengths
	localparam int COUNT_WIDTH = 16;

	// configuration register map
	typedef enum logic [2:0] {
		REG_HALF_LEN      = 3'd0,
		REG_BIT_GAP_LEN   = 3'd1,
		REG_ZERO_PULSES   = 3'd2,
		REG_ONE_PULSES    = 3'd3,
		REG_HIGH_LEVEL    = 3'd4,
		REG_LOW_LEVEL     = 3'd5,
		REG_MID_LEVEL     = 3'd6,
		REG_SMOOTH_FACTOR = 3'd7
	} cfg_idx_t;

	localparam logic [7:0] RST_HALF_LEN      = 8'd6;
	localparam logic [9:0] RST_BIT_GAP_LEN   = 10'd57;
	localparam logic [3:0] RST_ZERO_PULSES   = 4'd4;
	localparam logic [3:0] RST_ONE_PULSES    = 4'd9;
	localparam logic [7:0] RST_HIGH_LEVEL    = 8'd250;
	localparam logic [7:0] RST_LOW_LEVEL     = 8'd0;
	localparam logic [7:0] RST_MID_LEVEL     = 8'd128;
	localparam logic [8:0] RST_SMOOTH_FACTOR = 9'd218;
	localparam logic [8:0] GAIN_UNITY        = 9'd256;

	// segment within a bit
	typedef enum logic [2:0] {
		PH_HIGH = 3'b001,
		PH_LOW  = 3'b010,
		PH_GAP  = 3'b100
	} phase_t;

	typedef struct packed {
		logic       found;
		logic [2:0] pos;
	} live_t;

	// First bit, MSB down, among the first span bits that carries any sample.
	function automatic live_t first_live(input logic [7:0] bits, input logic [3:0] span,
			input logic live0, input logic live1);
		live_t r;
		r.found = 1'b0;
		r.pos   = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (4'(i) < span && (bits[7 - i] ? live1 : live0)) begin
				r.found = 1'b1;
				r.pos   = 3'(i);
			end
		end
		return r;
	endfunction

endpackage

// File: rtl/core/tape_pulse_bit_encoder.sv
// Channel  | Dir | Fields (lowest bit first)
// s_axis   | in  | tuser: load_valid[0] load_kind[1]; tdata: data_byte[7:0] silence_count[23:8]
// m_axis   | out | tdata: sample[7:0] busy_res[8] overrun[9] zero[15:10]
// cfg      | in  | cfg_we, cfg_addr (register index), cfg_wdata (10 bits)
//
// One word in, one word out; a new tick word is taken every cycle unless m_axis backpressure holds s_axis_tready low.
// Stages in order: input register, job sequencer stage, smoother/output register.
// The job state loop and the smoother loop each close within one stage.
// arst_n clears the job, the smoother and all valids; config returns to its defaults.
// Backpressure on m_axis fills empty stages first, then holds s_axis_tready low.
module tape_pulse_bit_encoder
	import tpbe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // data_byte[7:0], silence_count[23:8]
	input  logic [1:0]  s_axis_tuser,   // load_valid[0], load_kind[1]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // sample[7:0], busy_res[8], overrun[9]
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [9:0]  cfg_wdata
);

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	// config registers
	logic [7:0] half_q, hi_q, lo_q, mid_q;
	logic [9:0] gap_q;
	logic [3:0] zp_q, op_q;
	logic [8:0] k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= RST_HALF_LEN;
			gap_q  <= RST_BIT_GAP_LEN;
			zp_q   <= RST_ZERO_PULSES;
			op_q   <= RST_ONE_PULSES;
			hi_q   <= RST_HIGH_LEVEL;
			lo_q   <= RST_LOW_LEVEL;
			mid_q  <= RST_MID_LEVEL;
			k_q    <= RST_SMOOTH_FACTOR;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_addr))
				REG_HALF_LEN:      half_q <= cfg_wdata[7:0];
				REG_BIT_GAP_LEN:   gap_q  <= cfg_wdata;
				REG_ZERO_PULSES:   zp_q   <= cfg_wdata[3:0];
				REG_ONE_PULSES:    op_q   <= cfg_wdata[3:0];
				REG_HIGH_LEVEL:    hi_q   <= cfg_wdata[7:0];
				REG_LOW_LEVEL:     lo_q   <= cfg_wdata[7:0];
				REG_MID_LEVEL:     mid_q  <= cfg_wdata[7:0];
				REG_SMOOTH_FACTOR: k_q    <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	// stage handshake: each stage fills when empty or when its word moves on
	logic v1_s1, v2_s2, mv_q;
	logic rdy1, rdy2, rdy_o;
	logic step1, step2;

	assign rdy_o = !mv_q || m_axis_tready;
	assign rdy2  = !v2_s2 || rdy_o;
	assign rdy1  = !v1_s1 || rdy2;
	assign step1 = v1_s1 && rdy2;   // tick word enters the sequencer
	assign step2 = v2_s2 && rdy_o;  // raw level enters the smoother

	assign s_axis_tready = rdy1;
	assign m_axis_tvalid = mv_q;

	// input register
	logic        ld_v_s1, kind_s1;
	logic [7:0]  data_s1;
	logic [15:0] cnt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (rdy1) begin
			v1_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && s_axis_tvalid) begin
			ld_v_s1 <= s_axis_tuser[0];
			kind_s1 <= s_axis_tuser[1];
			data_s1 <= s_axis_tdata[7:0];
			cnt_s1  <= s_axis_tdata[23:8];
		end
	end

	// job state
	logic                   job_q, sil_q;
	logic [7:0]             shift_q;
	logic [2:0]             bi_q;
	logic [3:0]             pi_q;
	phase_t                 ph_q;
	logic [COUNT_WIDTH-1:0] cnt_q;

	// a bit value is live when it yields at least one sample
	logic live0, live1;
	assign live0 = (gap_q != '0) || (half_q != '0 && zp_q != '0);
	assign live1 = (gap_q != '0) || (half_q != '0 && op_q != '0);

	// load path: skip leading empty bits of the new byte
	logic                   do_load, ovr;
	live_t                  ld_live;
	logic [7:0]             ld_shift;
	logic [31:0]            cnt_w;
	logic [COUNT_WIDTH-1:0] cnt_sat;

	assign do_load  = ld_v_s1 && !job_q;
	assign ovr      = ld_v_s1 && job_q;
	assign ld_live  = first_live(data_s1, 4'd8, live0, live1);
	assign ld_shift = data_s1 << ld_live.pos;
	assign cnt_w    = 32'(cnt_s1);
	assign cnt_sat  = (cnt_w > 32'(CNT_MAX)) ? CNT_MAX : COUNT_WIDTH'(cnt_w);

	function automatic phase_t start_ph(input logic b, input logic [7:0] half,
			input logic [3:0] zp, input logic [3:0] op);
		return (half != '0 && (b ? op : zp) != '0) ? PH_HIGH : PH_GAP;
	endfunction

	// state seen by this tick: freshly loaded job or the running one
	logic                   cur_act, cur_sil;
	logic [7:0]             cur_shift;
	logic [2:0]             cur_bi;
	logic [3:0]             cur_pi;
	phase_t                 cur_ph;
	logic [COUNT_WIDTH-1:0] cur_cnt;

	always_comb begin
		if (do_load) begin
			cur_act   = kind_s1 ? (cnt_sat != '0) : ld_live.found;
			cur_sil   = kind_s1;
			cur_shift = ld_shift;
			cur_bi    = ld_live.pos;
			cur_pi    = 4'd0;
			cur_ph    = start_ph(ld_shift[7], half_q, zp_q, op_q);
			cur_cnt   = kind_s1 ? cnt_sat : '0;
		end else begin
			cur_act   = job_q;
			cur_sil   = sil_q;
			cur_shift = shift_q;
			cur_bi    = bi_q;
			cur_pi    = pi_q;
			cur_ph    = ph_q;
			cur_cnt   = cnt_q;
		end
	end

	// next-bit search from the bit after the current one
	logic [COUNT_WIDTH-1:0] cnt_up, cnt_dn;
	logic [3:0]             pl, pi_inc;
	logic [7:0]             sh1, nb_shift;
	live_t                  nb_live;

	assign cnt_up   = cur_cnt + 1'b1;
	assign cnt_dn   = cur_cnt - 1'b1;
	assign pl       = cur_shift[7] ? op_q : zp_q;
	assign pi_inc   = cur_pi + 4'd1;
	assign sh1      = cur_shift << 1;
	assign nb_live  = first_live(sh1, 4'd7 - {1'b0, cur_bi}, live0, live1);
	assign nb_shift = sh1 << nb_live.pos;

	logic                   nxt_act;
	logic [7:0]             nxt_shift;
	logic [2:0]             nxt_bi;
	logic [3:0]             nxt_pi;
	phase_t                 nxt_ph;
	logic [COUNT_WIDTH-1:0] nxt_cnt;
	logic [7:0]             raw;
	logic                   gap_fresh, adv_bit;

	always_comb begin
		nxt_act   = cur_act;
		nxt_shift = cur_shift;
		nxt_bi    = cur_bi;
		nxt_pi    = cur_pi;
		nxt_ph    = cur_ph;
		nxt_cnt   = cur_cnt;
		raw       = mid_q;
		gap_fresh = 1'b0;
		adv_bit   = 1'b0;
		if (cur_act && cur_sil) begin
			nxt_cnt = cnt_dn;
			nxt_act = (cnt_dn != '0);
		end else if (cur_act) begin
			case (cur_ph)
				PH_HIGH: raw = hi_q;
				PH_LOW:  raw = lo_q;
				default: raw = mid_q;
			endcase
			nxt_cnt = cnt_up;
			if ((cur_ph == PH_HIGH || cur_ph == PH_LOW) && cur_pi >= pl) begin
				// pulse count shrank under the running bit
				gap_fresh = 1'b1;
			end else begin
				case (cur_ph)
					PH_HIGH: begin
						if (cnt_up >= COUNT_WIDTH'(half_q)) begin
							if (half_q != '0) begin
								nxt_ph  = PH_LOW;
								nxt_cnt = '0;
							end else begin
								gap_fresh = 1'b1;
							end
						end
					end
					PH_LOW: begin
						if (cnt_up >= COUNT_WIDTH'(half_q)) begin
							if (pi_inc >= pl || half_q == '0) begin
								gap_fresh = 1'b1;
							end else begin
								nxt_ph  = PH_HIGH;
								nxt_cnt = '0;
								nxt_pi  = pi_inc;
							end
						end
					end
					default: begin
						if (cnt_up >= COUNT_WIDTH'(gap_q))
							adv_bit = 1'b1;
					end
				endcase
			end
			if (gap_fresh) begin
				if (gap_q != '0) begin
					nxt_ph  = PH_GAP;
					nxt_cnt = '0;
				end else begin
					adv_bit = 1'b1;
				end
			end
			if (adv_bit) begin
				if (nb_live.found) begin
					nxt_bi    = 3'(cur_bi + 3'd1 + nb_live.pos);
					nxt_shift = nb_shift;
					nxt_pi    = 4'd0;
					nxt_cnt   = '0;
					nxt_ph    = start_ph(nb_shift[7], half_q, zp_q, op_q);
				end else begin
					nxt_act = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_q   <= 1'b0;
			sil_q   <= 1'b0;
			shift_q <= '0;
			bi_q    <= '0;
			pi_q    <= '0;
			ph_q    <= PH_HIGH;
			cnt_q   <= '0;
		end else if (step1) begin
			job_q   <= nxt_act;
			sil_q   <= cur_sil;
			shift_q <= nxt_shift;
			bi_q    <= nxt_bi;
			pi_q    <= nxt_pi;
			ph_q    <= nxt_ph;
			cnt_q   <= nxt_cnt;
		end
	end

	// sequencer stage output
	logic [7:0] raw_s2;
	logic       busy_s2, ovr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (rdy2) begin
			v2_s2 <= v1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step1) begin
			raw_s2  <= raw;
			busy_s2 <= nxt_act;
			ovr_s2  <= ovr;
		end
	end

	// smoother: s + ((raw - s) * k) >>> 8, equal to the floor of the weighted mean
	logic [7:0]         smooth_q;
	logic [8:0]         gain;
	logic signed [8:0]  diff;
	logic signed [19:0] prod;
	logic signed [11:0] acc;

	assign gain = (k_q > GAIN_UNITY) ? GAIN_UNITY : k_q;
	assign diff = $signed({1'b0, raw_s2}) - $signed({1'b0, smooth_q});
	assign prod = 20'(diff * $signed({1'b0, gain}));
	assign acc  = $signed({4'b0, smooth_q}) + 12'(prod >>> 8);

	logic busy_q, ovr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q     <= 1'b0;
			smooth_q <= '0;
			busy_q   <= 1'b0;
			ovr_q    <= 1'b0;
		end else begin
			if (rdy_o)
				mv_q <= v2_s2;
			if (step2) begin
				smooth_q <= acc[7:0];
				busy_q   <= busy_s2;
				ovr_q    <= ovr_s2;
			end
		end
	end

	assign m_axis_tdata = {6'b0, ovr_q, busy_q, smooth_q};

	// an idle block never flags a dropped load
	a_no_ovr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step1 && !job_q) |=> !ovr_s2)
		else $error("overrun flagged with no job running");

	// a running silence job always has samples left
	a_sil_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(job_q && sil_q) |-> (cnt_q != '0))
		else $error("silence job active with empty count");

	// without a load an idle sequencer stays idle
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(step1 && !job_q && !ld_v_s1) |=> !job_q)
		else $error("job started without a load");

	// a dropped load never disturbs the running job's kind
	a_ovr_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(step1 && ovr) |=> (sil_q == $past(sil_q)))
		else $error("dropped load changed the job kind");

endmodule
